[rtl/core/swm_pkg.sv]
package swm_pkg;

    localparam int CFG_WIDTH = 7;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd3;

    typedef struct packed {
        logic item;
        logic shift;
        logic clear;
    } t_ctrl;

endpackage

[rtl/core/swm_cell.sv]
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int AGE_WIDTH    = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ctrl                          i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_left_keep,
    input  logic                           i_right_valid,
    input  logic        [AGE_WIDTH-1:0]    i_right_age,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_value,
    output logic                           o_keep,
    output logic                           o_valid,
    output logic        [AGE_WIDTH-1:0]    o_age,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic signed [SAMPLE_WIDTH-1:0] o_next_value
);

    logic                           r_valid;
    logic        [AGE_WIDTH-1:0]    r_age;
    logic signed [SAMPLE_WIDTH-1:0] r_value;

    logic                           n_valid;
    logic        [AGE_WIDTH-1:0]    n_age;
    logic signed [SAMPLE_WIDTH-1:0] n_value;

    logic                           w_src_valid;
    logic        [AGE_WIDTH-1:0]    w_src_age;
    logic signed [SAMPLE_WIDTH-1:0] w_src_value;

    always_comb begin
        w_src_valid = i_ctrl.shift ? i_right_valid : r_valid;
        w_src_age   = i_ctrl.shift ? i_right_age   : r_age;
        w_src_value = i_ctrl.shift ? i_right_value : r_value;
        o_keep      = w_src_valid && (!i_ctrl.item || (w_src_value >= i_sample));

        n_valid = w_src_valid;
        n_age   = w_src_age;
        n_value = w_src_value;
        if (i_ctrl.item) begin
            if (o_keep) begin
                n_valid = 1'b1;
                n_age   = w_src_age + AGE_WIDTH'(1);
            end else if (i_left_keep) begin
                n_valid = 1'b1;
                n_age   = '0;
                n_value = i_sample;
            end else begin
                n_valid = 1'b0;
                n_age   = '0;
            end
        end
        o_next_value = n_value;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
            n_age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
        end
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_age   = r_age;
    assign o_value = r_value;

endmodule

[rtl/core/sliding_window_maximum.sv]
// A result is registered and appears on the output in the cycle after its sample is
// accepted. Throughput: one sample per cycle while neither an expiry stall nor output
// back-pressure holds the input; the row of cells updates the whole deque each cycle.
// After a shrink, a waiting sample and writes stall while expired entries shift out.
// Reset (synchronous, active low): deque and sample count empty, window size 3.
module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic        [CFG_WIDTH-1:0]    i_cfg_window_size,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last_in_stream,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_window_max
);

    localparam int KW = $clog2(WINDOW_MAX + 1);

    logic        [CFG_WIDTH-1:0]    r_window_size;
    logic        [KW-1:0]           r_seen;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_window_max;

    logic                           w_keep       [WINDOW_MAX];
    logic                           w_valid      [WINDOW_MAX];
    logic        [KW-1:0]           w_age        [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] w_value      [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] w_next_value [WINDOW_MAX];

    logic          [KW-1:0] w_k;
    logic          [KW-1:0] w_seen_next;
    logic          [KW:0]   w_age0_inc;
    logic                   w_expire0;
    logic                   w_pre_expire;
    logic                   w_in_fire;
    logic                   w_emit;
    t_ctrl                  w_ctrl;

    always_comb begin
        if (r_window_size == '0) begin
            w_k = KW'(1);
        end else if (32'(r_window_size) > 32'(WINDOW_MAX)) begin
            w_k = KW'(WINDOW_MAX);
        end else begin
            w_k = KW'(r_window_size);
        end
    end

    assign w_age0_inc = {1'b0, w_age[0]} + (KW+1)'(1);
    assign w_expire0  = w_valid[0] && (w_age0_inc >= {1'b0, w_k});

    generate
        if (WINDOW_MAX > 1) begin : g_pre
            logic [KW:0] w_age1_inc;
            assign w_age1_inc   = {1'b0, w_age[1]} + (KW+1)'(1);
            assign w_pre_expire = i_in_valid && w_valid[1] && (w_age1_inc >= {1'b0, w_k});
        end else begin : g_no_pre
            assign w_pre_expire = 1'b0;
        end
    endgenerate

    assign o_in_ready  = !w_pre_expire && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = !w_pre_expire;
    assign w_in_fire   = i_in_valid && o_in_ready;

    assign w_ctrl.item  = w_in_fire;
    assign w_ctrl.shift = w_pre_expire || (w_in_fire && w_expire0);
    assign w_ctrl.clear = w_in_fire && i_last_in_stream;

    assign w_seen_next = (r_seen == KW'(WINDOW_MAX)) ? r_seen : r_seen + KW'(1);
    assign w_emit      = w_seen_next >= w_k;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            logic                           w_left_keep;
            logic                           w_right_valid;
            logic        [KW-1:0]           w_right_age;
            logic signed [SAMPLE_WIDTH-1:0] w_right_value;

            if (gi == 0) begin : g_head
                assign w_left_keep = 1'b1;
            end else begin : g_body
                assign w_left_keep = w_keep[gi-1];
            end

            if (gi == WINDOW_MAX - 1) begin : g_tail
                assign w_right_valid = 1'b0;
                assign w_right_age   = '0;
                assign w_right_value = '0;
            end else begin : g_link
                assign w_right_valid = w_valid[gi+1];
                assign w_right_age   = w_age[gi+1];
                assign w_right_value = w_value[gi+1];
            end

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .AGE_WIDTH    (KW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_sample      (i_sample),
                .i_left_keep   (w_left_keep),
                .i_right_valid (w_right_valid),
                .i_right_age   (w_right_age),
                .i_right_value (w_right_value),
                .o_keep        (w_keep[gi]),
                .o_valid       (w_valid[gi]),
                .o_age         (w_age[gi]),
                .o_value       (w_value[gi]),
                .o_next_value  (w_next_value[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_RESET;
            r_seen        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_window_size <= i_cfg_window_size;
            end
            if (w_in_fire) begin
                r_seen      <= i_last_in_stream ? '0 : w_seen_next;
                r_out_valid <= w_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_fire && w_emit) begin
            r_window_max <= w_next_value[0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_window_max;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_last_in_stream) |=> (!w_valid[0] && r_seen == '0))
        else $error("deque not cleared after end of stream");

    a_front_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !i_last_in_stream) |=> (w_valid[0] && w_age[0] < $past(w_k)))
        else $error("front entry missing or outside the window");

    generate
        if (WINDOW_MAX > 1) begin : g_chk
            a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_valid[1] |-> w_valid[0])
                else $error("valid cells do not form a prefix");
        end
    endgenerate

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import swm_pkg::*;

    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_PERCENT  = 18;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_HI = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_LO = 32'sh8000_0000;

    typedef enum int {
        STYLE_MIXED,
        STYLE_FALLING,
        STYLE_RISING,
        STYLE_FEW
    } t_stream_style;

    logic                           i_clk             = 1'b0;
    logic                           i_rst_n           = 1'b0;
    logic                           i_cfg_valid       = 1'b0;
    logic                           o_cfg_ready;
    logic        [CFG_WIDTH-1:0]    i_cfg_window_size = CFG_RESET;
    logic                           i_in_valid        = 1'b0;
    logic                           o_in_ready;
    logic signed [SAMPLE_WIDTH-1:0] i_sample          = '0;
    logic                           i_last_in_stream  = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready       = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] o_window_max;

    bit idle_enable = 1'b1;
    int mismatch_count = 0;

    logic        [CFG_WIDTH-1:0]    window_reg = CFG_RESET;
    logic signed [SAMPLE_WIDTH-1:0] dq_value [WINDOW_MAX];
    int                             dq_age   [WINDOW_MAX];
    int                             dq_fill    = 0;
    int                             seen_count = 0;

    logic signed [SAMPLE_WIDTH-1:0] expected_max [$];

    sliding_window_maximum #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_window_size (i_cfg_window_size),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_sample          (i_sample),
        .i_last_in_stream  (i_last_in_stream),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_window_max      (o_window_max)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int effective_window(input logic [CFG_WIDTH-1:0] w);
        if (w == 0) begin
            return 1;
        end
        if (w > WINDOW_MAX) begin
            return WINDOW_MAX;
        end
        return int'(w);
    endfunction

    function automatic void drop_front();
        for (int i = 1; i < dq_fill; i++) begin
            dq_value[i-1] = dq_value[i];
            dq_age[i-1]   = dq_age[i];
        end
        dq_fill--;
    endfunction

    function automatic bit predict_window_max(input logic signed [SAMPLE_WIDTH-1:0] s,
                                              input logic last,
                                              output logic signed [SAMPLE_WIDTH-1:0] mx);
        int k;
        bit hit;
        k = effective_window(window_reg);
        for (int i = 0; i < dq_fill; i++) begin
            if (dq_age[i] < WINDOW_MAX) begin
                dq_age[i]++;
            end
        end
        while (dq_fill > 0 && dq_age[0] >= k) begin
            drop_front();
        end
        while (dq_fill > 0 && dq_value[dq_fill-1] < s) begin
            dq_fill--;
        end
        if (dq_fill >= WINDOW_MAX) begin
            drop_front();
        end
        dq_value[dq_fill] = s;
        dq_age[dq_fill]   = 0;
        dq_fill++;
        if (seen_count < WINDOW_MAX) begin
            seen_count++;
        end
        hit = (seen_count >= k);
        mx  = dq_value[0];
        if (last) begin
            dq_fill    = 0;
            seen_count = 0;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= !idle_enable || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin : check_results
        logic signed [SAMPLE_WIDTH-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_max.size() == 0) begin
                report_mismatch($sformatf("unexpected window_max %0d", o_window_max));
            end else begin
                want = expected_max.pop_front();
                if (o_window_max !== want) begin
                    report_mismatch($sformatf("window_max got %0d want %0d",
                                              o_window_max, want));
                end
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic last);
        logic signed [SAMPLE_WIDTH-1:0] mx;
        if (idle_enable && $urandom_range(99, 0) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk);
            while (idle_enable && $urandom_range(99, 0) < IDLE_PERCENT);
        end
        i_in_valid       <= 1'b1;
        i_sample         <= s;
        i_last_in_stream <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_window_max(s, last, mx)) begin
            expected_max.push_back(mx);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_max.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_window(input logic [CFG_WIDTH-1:0] w);
        drain_results();
        i_cfg_valid       <= 1'b1;
        i_cfg_window_size <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_reg = w;
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(
            input t_stream_style style, input logic signed [SAMPLE_WIDTH-1:0] prev);
        logic signed [SAMPLE_WIDTH-1:0] s;
        case (style)
            STYLE_FALLING: begin
                s = prev - int'($urandom_range(3, 0));
            end
            STYLE_RISING: begin
                s = prev + int'($urandom_range(3, 0));
            end
            STYLE_FEW: begin
                s = int'($urandom_range(3, 0)) * 100 - 100;
            end
            default: begin
                case ($urandom_range(9, 0))
                    5, 6, 7: s = int'($urandom_range(15, 0)) - 8;
                    8: begin
                        case ($urandom_range(3, 0))
                            0: s = SAMPLE_HI;
                            1: s = SAMPLE_LO;
                            2: s = '0;
                            default: s = -1;
                        endcase
                    end
                    9: s = prev;
                    default: s = $urandom;
                endcase
            end
        endcase
        return s;
    endfunction

    task automatic test_default_window();
        send_sample(SAMPLE_HI, 1'b0);
        send_sample(SAMPLE_LO, 1'b0);
        send_sample(SAMPLE_LO, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b1);
        // stream shorter than the window
        send_sample(5, 1'b0);
        send_sample(7, 1'b1);
        // equal values stay in the deque
        send_sample(9, 1'b0);
        send_sample(9, 1'b0);
        send_sample(9, 1'b0);
        send_sample(2, 1'b0);
        send_sample(9, 1'b1);
    endtask

    task automatic test_window_bounds();
        load_window(1);
        send_sample(-5, 1'b0);
        send_sample(3, 1'b1);
        load_window(0);
        send_sample(7, 1'b0);
        send_sample(7, 1'b1);
        load_window(2);
        send_sample(SAMPLE_LO, 1'b0);
        send_sample(SAMPLE_LO, 1'b0);
        send_sample(-1, 1'b1);
    endtask

    task automatic test_window_change();
        load_window(4);
        send_sample(10, 1'b0);
        send_sample(8, 1'b0);
        send_sample(6, 1'b0);
        send_sample(4, 1'b0);
        // shrink mid-stream: older entries expire on the next transaction
        load_window(2);
        send_sample(1, 1'b0);
        send_sample(1, 1'b1);
    endtask

    task automatic test_random_streams();
        int phase;
        int phase_budget;
        int left_in_stream;
        int items_done;
        int eff;
        logic [CFG_WIDTH-1:0] win;
        t_stream_style style;
        logic signed [SAMPLE_WIDTH-1:0] prev;
        phase          = 0;
        items_done     = 0;
        left_in_stream = 0;
        style          = STYLE_MIXED;
        prev           = '0;
        while (items_done < RANDOM_ITEMS) begin
            case (phase)
                0: win = 64;
                1: win = 127;
                2: win = 65;
                3: win = 0;
                default: begin
                    if ($urandom_range(9, 0) == 0) begin
                        win = CFG_WIDTH'($urandom_range(127, 0));
                    end else begin
                        win = CFG_WIDTH'($urandom_range(8, 1));
                    end
                end
            endcase
            idle_enable = !(phase >= 6 && phase <= 8);
            load_window(win);
            eff = effective_window(win);
            phase_budget = $urandom_range(120, 40);
            while (phase_budget > 0 && items_done < RANDOM_ITEMS) begin
                if (left_in_stream == 0) begin
                    if ($urandom_range(4, 0) == 0) begin
                        left_in_stream = $urandom_range(eff, 1);
                    end else begin
                        left_in_stream = $urandom_range(2 * eff + 8, eff);
                    end
                    style = t_stream_style'($urandom_range(3, 0));
                    prev  = $urandom;
                end
                prev = pick_sample(style, prev);
                left_in_stream--;
                send_sample(prev, left_in_stream == 0);
                phase_budget--;
                items_done++;
                if ($urandom_range(199, 0) == 0) begin
                    drain_results();
                end
            end
            phase++;
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_window();
        test_window_bounds();
        test_window_change();
        test_random_streams();
        drain_results();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_maximum.sv
tb/tb_top.sv
